// ----- hdl/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// sensor frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int unsigned MAX_PAYLOAD = 255;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic [7:0] VERSION_RESET = 8'd1;
    localparam logic [7:0] TYPE_RESET    = 8'd16;
    localparam logic [7:0] LENGTH_RESET  = 8'd52;

    // configuration register indexes
    localparam logic [1:0] CFG_PROTOCOL_VERSION = 2'd0;
    localparam logic [1:0] CFG_MESSAGE_TYPE     = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_LENGTH   = 2'd2;

    // position in the byte sequence one transaction produces
    typedef enum logic [12:0] {
        STEP_SYNC0   = 13'b0000000000001,
        STEP_SYNC1   = 13'b0000000000010,
        STEP_VERSION = 13'b0000000000100,
        STEP_TYPE    = 13'b0000000001000,
        STEP_LEN_LO  = 13'b0000000010000,
        STEP_LEN_HI  = 13'b0000000100000,
        STEP_SEQ_LO  = 13'b0000001000000,
        STEP_SEQ_HI  = 13'b0000010000000,
        STEP_RSV0    = 13'b0000100000000,
        STEP_RSV1    = 13'b0001000000000,
        STEP_PAYLOAD = 13'b0010000000000,
        STEP_CRC_LO  = 13'b0100000000000,
        STEP_CRC_HI  = 13'b1000000000000
    } step_t;

    typedef struct packed {
        logic clear;
        logic update;
    } crc_ctrl_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- hdl/sfb_crc16.sv -----
// ----------------------------------------------------------------------------
// sfb_crc16
// Running CRC-16/CCITT-FALSE register, one byte folded in per cycle while update is high.
// ----------------------------------------------------------------------------
module sfb_crc16 (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfb_pkg::crc_ctrl_t   ctrl,
    input  logic [7:0]           data,
    output logic [15:0]          crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctrl.clear) begin
            crc_next = sfb_pkg::CRC_INIT;
        end else if (ctrl.update) begin
            crc_next = sfb_pkg::crc_byte(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= sfb_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// ----- hdl/sensor_frame_builder_crc16_core.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16_core
// Wraps payload bytes into framed packets with a CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one payload byte per transaction. m_ channel: the framed
//   byte stream, one byte per transaction, m_frame_end high on the last
//   (high) CRC byte of each frame. cfg_ channel writes protocol version,
//   message type and payload length; cfg_ready is always high, and writes
//   belong between frames while the block is idle.
//   A payload byte is held in an input register and expanded there into its
//   output bytes, one per cycle unless m_ready holds the output register,
//   into the output register. Each byte thus passes the input register and
//   then the output register before it can be taken. A byte that opens a
//   frame yields 11 output bytes (10 header + payload), the closing byte adds
//   2 CRC bytes, a byte in between yields 1. Throughput is set by the output
//   register: one byte per cycle while m_ready stays high. The next payload
//   byte is accepted in the cycle the last output byte of the current one is
//   loaded, so mid-frame payload bytes flow at one per cycle unless stalled.
//   Reset clears the registers to their defaults, the sequence number to 0
//   and starts a new frame. When m_ready is low the output register holds
//   its byte, the expansion pauses and s_ready drops once the input register
//   is busy.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc16_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]  version_reg;
    logic [7:0]  type_reg;
    logic [7:0]  length_reg;
    logic [15:0] seq_reg;
    logic [15:0] seq_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;

    logic           item_valid_reg;
    logic [7:0]     item_byte_reg;
    sfb_pkg::step_t step_reg;
    sfb_pkg::step_t step_adv;

    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_end_reg;

    logic               out_load;
    logic               frame_last;
    logic               item_done;
    logic               accept;
    logic [7:0]         eff_len;
    logic [7:0]         emit_byte;
    logic [15:0]        crc;
    sfb_pkg::crc_ctrl_t crc_ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= sfb_pkg::VERSION_RESET;
            type_reg    <= sfb_pkg::TYPE_RESET;
            length_reg  <= sfb_pkg::LENGTH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sfb_pkg::CFG_PROTOCOL_VERSION: version_reg <= cfg_data;
                sfb_pkg::CFG_MESSAGE_TYPE:     type_reg    <= cfg_data;
                sfb_pkg::CFG_PAYLOAD_LENGTH:   length_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero length counts as one, clamp to the maximum payload length
    always_comb begin
        eff_len = length_reg;
        if (eff_len == 8'd0) begin
            eff_len = 8'd1;
        end
        if (16'(eff_len) > 16'(sfb_pkg::MAX_PAYLOAD)) begin
            eff_len = 8'(sfb_pkg::MAX_PAYLOAD);
        end
    end

    assign frame_last = ({1'b0, count_reg} + 9'd1) >= {1'b0, eff_len};
    assign out_load   = item_valid_reg && (!m_valid_reg || m_ready);
    assign item_done  = out_load && ((step_reg == sfb_pkg::STEP_CRC_HI) ||
                        ((step_reg == sfb_pkg::STEP_PAYLOAD) && !frame_last));
    assign s_ready    = !item_valid_reg || item_done;
    assign accept     = s_valid && s_ready;

    always_comb begin
        emit_byte = sfb_pkg::ZERO_BYTE;
        step_adv  = sfb_pkg::STEP_SYNC0;
        case (step_reg)
            sfb_pkg::STEP_SYNC0: begin
                emit_byte = sfb_pkg::SYNC_FIRST;
                step_adv  = sfb_pkg::STEP_SYNC1;
            end
            sfb_pkg::STEP_SYNC1: begin
                emit_byte = sfb_pkg::SYNC_SECOND;
                step_adv  = sfb_pkg::STEP_VERSION;
            end
            sfb_pkg::STEP_VERSION: begin
                emit_byte = version_reg;
                step_adv  = sfb_pkg::STEP_TYPE;
            end
            sfb_pkg::STEP_TYPE: begin
                emit_byte = type_reg;
                step_adv  = sfb_pkg::STEP_LEN_LO;
            end
            sfb_pkg::STEP_LEN_LO: begin
                emit_byte = eff_len;
                step_adv  = sfb_pkg::STEP_LEN_HI;
            end
            sfb_pkg::STEP_LEN_HI: begin
                // effective length never exceeds one byte
                emit_byte = sfb_pkg::ZERO_BYTE;
                step_adv  = sfb_pkg::STEP_SEQ_LO;
            end
            sfb_pkg::STEP_SEQ_LO: begin
                emit_byte = seq_reg[7:0];
                step_adv  = sfb_pkg::STEP_SEQ_HI;
            end
            sfb_pkg::STEP_SEQ_HI: begin
                emit_byte = seq_reg[15:8];
                step_adv  = sfb_pkg::STEP_RSV0;
            end
            sfb_pkg::STEP_RSV0: begin
                emit_byte = sfb_pkg::ZERO_BYTE;
                step_adv  = sfb_pkg::STEP_RSV1;
            end
            sfb_pkg::STEP_RSV1: begin
                emit_byte = sfb_pkg::ZERO_BYTE;
                step_adv  = sfb_pkg::STEP_PAYLOAD;
            end
            sfb_pkg::STEP_PAYLOAD: begin
                emit_byte = item_byte_reg;
                step_adv  = sfb_pkg::STEP_CRC_LO;
            end
            sfb_pkg::STEP_CRC_LO: begin
                emit_byte = crc[7:0];
                step_adv  = sfb_pkg::STEP_CRC_HI;
            end
            sfb_pkg::STEP_CRC_HI: begin
                emit_byte = crc[15:8];
                step_adv  = sfb_pkg::STEP_SYNC0;
            end
            default: begin
                emit_byte = sfb_pkg::ZERO_BYTE;
                step_adv  = sfb_pkg::STEP_SYNC0;
            end
        endcase
    end

    // restart the CRC at a frame start and after the trailer; fold in
    // everything from the version byte through the payload
    always_comb begin
        crc_ctrl.clear  = out_load && ((step_reg == sfb_pkg::STEP_SYNC0) ||
                                       (step_reg == sfb_pkg::STEP_CRC_HI));
        crc_ctrl.update = out_load && (step_reg != sfb_pkg::STEP_SYNC0) &&
                          (step_reg != sfb_pkg::STEP_SYNC1) &&
                          (step_reg != sfb_pkg::STEP_CRC_LO) &&
                          (step_reg != sfb_pkg::STEP_CRC_HI);
    end

    sfb_crc16 u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data    (emit_byte),
        .crc     (crc)
    );

    always_comb begin
        count_next = count_reg;
        if (out_load && (step_reg == sfb_pkg::STEP_PAYLOAD)) begin
            count_next = frame_last ? 8'd0 : count_reg + 8'd1;
        end
    end

    assign seq_next = (out_load && (step_reg == sfb_pkg::STEP_CRC_HI)) ?
                      seq_reg + 16'd1 : seq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= '0;
            count_reg <= '0;
        end else begin
            seq_reg   <= seq_next;
            count_reg <= count_next;
        end
    end

    // input register: a new transaction starts with the header when the
    // frame count is back at zero, otherwise with the payload byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= sfb_pkg::STEP_SYNC0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
            step_reg       <= (count_next == 8'd0) ? sfb_pkg::STEP_SYNC0
                                                   : sfb_pkg::STEP_PAYLOAD;
        end else if (item_done) begin
            item_valid_reg <= 1'b0;
        end else if (out_load) begin
            step_reg <= step_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_byte_reg <= s_payload_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg <= emit_byte;
            m_end_reg  <= (step_reg == sfb_pkg::STEP_CRC_HI);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_frame_end = m_end_reg;

`ifndef NO_ASSERTIONS
    // a header is only ever produced at the start of a frame
    a_header_at_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && (step_reg != sfb_pkg::STEP_PAYLOAD) &&
        (step_reg != sfb_pkg::STEP_CRC_LO) && (step_reg != sfb_pkg::STEP_CRC_HI)
        |-> (count_reg == 8'd0))
        else $error("header step outside frame start");

    // CRC is at its initial value when the second sync byte goes out
    a_crc_init_at_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && (step_reg == sfb_pkg::STEP_SYNC1)
        |-> (crc == sfb_pkg::CRC_INIT))
        else $error("CRC not initialized at frame start");

    // frame end leaves the payload count cleared
    a_end_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_end_reg |-> (count_reg == 8'd0))
        else $error("frame ended with payload count pending");

    // a new transaction is taken only when the input register frees up
    a_accept_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!item_valid_reg || item_done))
        else $error("input register overwritten");

    // the sequence number advances exactly when a frame end is loaded
    a_seq_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg != $past(seq_reg)) |-> ($past(out_load) &&
        ($past(step_reg) == sfb_pkg::STEP_CRC_HI)))
        else $error("sequence number changed outside frame end");
`endif

endmodule

// ----- dv/sfb_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_frame_checker
// Watches the payload, framed-output and register channels of the sensor
// frame builder. Keeps a shadow of the registers and the frame state and
// expands each accepted payload byte into the framed bytes it must produce.
// Each output transaction is checked against the oldest of those bytes.
// ----------------------------------------------------------------------------
module sfb_frame_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_frame_end,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } framed_byte_t;

    framed_byte_t expected_bytes[$];

    // shadow registers
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_msg_type;
    logic [7:0]  frame_len_cfg;

    // frame state
    logic [15:0] seq_num;
    int          frame_pos;
    logic [15:0] frame_crc;

    // CRC-16/CCITT-FALSE, one data bit at a time, MSB first
    function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc_in,
                                                   input logic [7:0]  octet);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ octet[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ sfb_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic emit_plain(input logic [7:0] b, input logic last_of_frame);
        framed_byte_t fb;
        fb.out_byte  = b;
        fb.frame_end = last_of_frame;
        expected_bytes.push_back(fb);
    endtask

    task automatic emit_covered(input logic [7:0] b);
        frame_crc = crc_ccitt_next(frame_crc, b);
        emit_plain(b, 1'b0);
    endtask

    task automatic expand_payload(input logic [7:0] pb);
        logic [15:0] frame_len;
        frame_len = {8'h00, frame_len_cfg};
        if (frame_len == 16'd0) begin
            frame_len = 16'd1;
        end
        if (frame_len > sfb_pkg::MAX_PAYLOAD) begin
            frame_len = 16'(sfb_pkg::MAX_PAYLOAD);
        end

        if (frame_pos == 0) begin
            frame_crc = sfb_pkg::CRC_INIT;
            emit_plain(sfb_pkg::SYNC_FIRST, 1'b0);
            emit_plain(sfb_pkg::SYNC_SECOND, 1'b0);
            emit_covered(hdr_version);
            emit_covered(hdr_msg_type);
            emit_covered(frame_len[7:0]);
            emit_covered(frame_len[15:8]);
            emit_covered(seq_num[7:0]);
            emit_covered(seq_num[15:8]);
            emit_covered(sfb_pkg::ZERO_BYTE);
            emit_covered(sfb_pkg::ZERO_BYTE);
        end

        emit_covered(pb);
        frame_pos++;

        // close on reaching or passing the length in force now
        if (frame_pos >= frame_len) begin
            emit_plain(frame_crc[7:0], 1'b0);
            emit_plain(frame_crc[15:8], 1'b1);
            seq_num   = seq_num + 16'd1;
            frame_pos = 0;
            frame_crc = sfb_pkg::CRC_INIT;
        end
    endtask

    always @(posedge aclk) begin
        framed_byte_t want;
        if (!aresetn) begin
            hdr_version   = sfb_pkg::VERSION_RESET;
            hdr_msg_type  = sfb_pkg::TYPE_RESET;
            frame_len_cfg = sfb_pkg::LENGTH_RESET;
            seq_num       = 16'd0;
            frame_pos     = 0;
            frame_crc     = sfb_pkg::CRC_INIT;
            mismatches    = 0;
            expected_bytes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output transaction: out_byte 0x%02h frame_end %0b",
                           m_out_byte, m_frame_end);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.out_byte, m_out_byte);
                        mismatches++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.frame_end, m_frame_end);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sfb_pkg::CFG_PROTOCOL_VERSION: hdr_version   = cfg_data;
                    sfb_pkg::CFG_MESSAGE_TYPE:     hdr_msg_type  = cfg_data;
                    sfb_pkg::CFG_PAYLOAD_LENGTH:   frame_len_cfg = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                expand_payload(s_payload_byte);
            end
        end
        outstanding = expected_bytes.size();
    end

endmodule

// ----- dv/sensor_frame_builder_crc16_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16_core_tb
// Drives payload bytes and register writes into the frame builder with random
// gaps and output back-pressure, including one long output stall. A directed
// part covers reset defaults, length extremes and mid-frame register writes;
// a random part sweeps register settings. The frame checker reports errors.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc16_core_tb;

    localparam int         IDLE_PCT    = 27;
    localparam int         RAND_ITEMS  = 355;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_payload_byte = 8'h00;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_frame_end;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index      = 2'd0;
    logic [7:0] cfg_data       = 8'h00;

    int mismatches;
    int outstanding;
    int s_idle_pct   = IDLE_PCT;
    int m_idle_pct   = IDLE_PCT;
    bit hold_request = 1'b0;
    int cycle_count;

    sensor_frame_builder_crc16_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    sfb_frame_checker u_frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // output back-pressure; a hold request stalls the receiver for a long stretch
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    // call at a rising edge; returns at the edge where the transaction happened
    task automatic send_payload(input logic [7:0] b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drop valid and wait for every predicted byte to drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        int         rand_items;
        int         phase;
        int         eff_len;
        int         burst;
        logic [7:0] len_sel;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults in the header, then shorten the length mid-frame
        send_payload(8'h00);
        wait_idle();
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'd2);
        send_payload(8'hFF);
        wait_idle();

        // zero length counts as one; unmapped index is ignored
        write_reg(sfb_pkg::CFG_PROTOCOL_VERSION, 8'h00);
        write_reg(sfb_pkg::CFG_MESSAGE_TYPE, 8'hFF);
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'h00);
        write_reg(CFG_UNMAPPED, 8'hFF);
        send_payload(8'hA5);
        send_payload(8'h5A);
        wait_idle();

        write_reg(sfb_pkg::CFG_PROTOCOL_VERSION, 8'hFF);
        write_reg(sfb_pkg::CFG_MESSAGE_TYPE, 8'h00);
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'd3);
        send_payload(8'h01);
        send_payload(8'h7F);
        send_payload(8'h80);
        wait_idle();

        // length dropped below the count already taken closes on the next byte
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'd4);
        send_payload(8'hFE);
        send_payload(8'h55);
        wait_idle();
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'd1);
        send_payload(8'hAA);
        wait_idle();

        // version and type written mid-frame show only in the next header
        write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, 8'd3);
        send_payload(8'h12);
        wait_idle();
        write_reg(sfb_pkg::CFG_PROTOCOL_VERSION, 8'h3C);
        write_reg(sfb_pkg::CFG_MESSAGE_TYPE, 8'hC3);
        send_payload(8'h34);
        send_payload(8'h56);
        send_payload(8'h78);
        send_payload(8'h9A);
        send_payload(8'hBC);
        wait_idle();

        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS) begin
            phase++;
            s_idle_pct = (phase >= 6 && phase <= 8) ? 0 : IDLE_PCT;
            m_idle_pct = (phase >= 6 && phase <= 8) ? 0 : IDLE_PCT;

            if (phase == 3) begin
                len_sel = 8'd255;
            end else begin
                case ($urandom_range(9))
                    0:       len_sel = 8'd0;
                    1:       len_sel = 8'($urandom_range(16, 5));
                    default: len_sel = 8'($urandom_range(4, 1));
                endcase
            end
            write_reg(sfb_pkg::CFG_PROTOCOL_VERSION, 8'($urandom_range(255)));
            write_reg(sfb_pkg::CFG_MESSAGE_TYPE, 8'($urandom_range(255)));
            write_reg(sfb_pkg::CFG_PAYLOAD_LENGTH, len_sel);
            eff_len = (len_sel == 8'd0) ? 1 : int'(len_sel);

            if (phase == 3) begin
                // stall the receiver while the long frame keeps coming
                hold_request = 1'b1;
                burst = eff_len;
            end else if ($urandom_range(3) == 0) begin
                // ragged burst: may stop mid-frame before the next writes
                burst = $urandom_range(2 * eff_len, 1);
            end else begin
                burst = eff_len * $urandom_range(4, 1);
            end

            repeat (burst) send_payload(8'($urandom_range(255)));
            rand_items += burst;
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
